### rtl/wpf_pkg.sv
// Shared types and codes for the waypoint path follower.
package wpf_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_PLAY   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_PAUSE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_HOP_CAP = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic [1:0] CSR_SPEED   = 2'd0;
   localparam logic [1:0] CSR_LOOP    = 2'd1;
   localparam logic [1:0] CSR_LINK    = 2'd2;
   localparam logic [1:0] CSR_REVERSE = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [31:0]        delta_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               path_ended;
      logic [5:0]         from_index;
      logic [5:0]         to_index;
      logic [6:0]         point_total;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef enum logic [3:0] {
      S_IDLE, S_TRAV, S_RD, S_DIFF, S_SQ, S_SQRT, S_CHK,
      S_DIV, S_MOVE, S_SNAP_RD, S_SNAP, S_DONE
   } state_type;

endpackage

### rtl/waypoint_path_follower_top.sv
// Waypoint path follower: point memory, segment walk, sqrt and divide units.
// Add and pause strobe the result in the cycle after start; play does too, or
// rewinds first and snaps to point 0. Update: travel product, then per segment
// a memory read, 3 squares and a 34-step square root, a partial move with a
// 31-step divide and 3 scales, and a snap to the end point at the path end.
// One transaction at a time: busy stays high until the result strobe is done.
// Synchronous reset clears state, count, indices, position, flags and config;
// the point memory holds garbage until written.
module waypoint_path_follower_top #(
   parameter int MAX_HOPS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  wpf_pkg::req_type req_data,
   output logic            rsp_valid,
   output wpf_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);
   import wpf_pkg::*;

   localparam int HOP_W = $clog2(MAX_HOPS + 1);

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

   state_type           state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    prev_ff, prev_in, next_ff, next_in;
   point_type           pos_ff, pos_in;
   logic                started_ff, started_in, ended_ff, ended_in, paused_ff, paused_in;
   logic [31:0]         speed_ff, speed_in;
   logic                loop_ff, loop_in, link_ff, link_in, rev_ff, rev_in;
   req_type             req_ff, req_in;
   logic [1:0]          status_ff, status_in;
   logic                hop_mode_ff, hop_mode_in;
   logic [HOP_W-1:0]    hops_ff, hops_in;
   logic [47:0]         trans_ff, trans_in;
   logic signed [32:0]  d_ff [3];
   logic signed [32:0]  d_in [3];
   logic [65:0]         prod_ff, acc_ff, acc_in;
   logic [67:0]         rad_ff, rad_in;
   logic [35:0]         rem_ff, rem_in;
   logic [33:0]         root_ff, root_in;
   logic [34:0]         divr_ff, divr_in;
   logic [30:0]         quo_ff, quo_in;
   logic [IDX_W-1:0]    snap_addr_ff, snap_addr_in;

   point_type           mem [MAX_POINTS];
   point_type           rd_a_ff, rd_b_ff, mem_wd;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa, rd_addr_a, rd_addr_b;

   logic [32:0]         mul_a, mul_b;
   logic [65:0]         prod;

   logic [IDX_W-1:0]    prev_tmp, next_tmp, n_m1, n_m2;
   logic [CNT_W-1:0]    prev_p1, next_p1, count_m1, count_m2;
   logic [37:0]         rem_try, trial;
   logic [34:0]         div_sh;
   logic [32:0]         off;
   logic [31:0]         off32;
   logic                accept;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_DONE);

   assign rsp_data.pos_x       = pos_ff.x;
   assign rsp_data.pos_y       = pos_ff.y;
   assign rsp_data.pos_z       = pos_ff.z;
   assign rsp_data.path_ended  = ended_ff;
   assign rsp_data.from_index  = prev_ff;
   assign rsp_data.to_index    = next_ff;
   assign rsp_data.point_total = count_ff;
   assign rsp_data.status      = status_ff;

   assign prod      = mul_a * mul_b;
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);
   assign n_m1      = count_m1[IDX_W-1:0];
   assign n_m2      = count_m2[IDX_W-1:0];
   assign prev_p1   = {1'b0, prev_ff} + CNT_W'(1);
   assign next_p1   = {1'b0, next_ff} + CNT_W'(1);
   assign rem_try   = {rem_ff, rad_ff[67:66]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign div_sh    = (cnt_ff == 6'd0) ? divr_ff : {divr_ff[33:0], 1'b0};
   assign off       = prod_ff[62:30];
   assign off32     = off[31:0];

   // Segment target is at "to" ("from" in reverse); the start comes from memory only on a hop.
   assign rd_addr_a = (state_ff == S_SNAP_RD) ? snap_addr_ff : (rev_ff ? next_ff : prev_ff);
   assign rd_addr_b = rev_ff ? prev_ff : next_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      pos_in       = pos_ff;
      started_in   = started_ff;
      ended_in     = ended_ff;
      paused_in    = paused_ff;
      speed_in     = speed_ff;
      loop_in      = loop_ff;
      link_in      = link_ff;
      rev_in       = rev_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      hop_mode_in  = hop_mode_ff;
      hops_in      = hops_ff;
      trans_in     = trans_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      divr_in      = divr_ff;
      quo_in       = quo_ff;
      snap_addr_in = snap_addr_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[IDX_W-1:0];
      mem_wd       = '{x: req_data.point_x, y: req_data.point_y, z: req_data.point_z};
      mul_a        = '0;
      mul_b        = '0;
      prev_tmp     = prev_ff;
      next_tmp     = next_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPEED:   speed_in = csr_data;
            CSR_LOOP:    loop_in  = csr_data[0];
            CSR_LINK:    link_in  = csr_data[0];
            CSR_REVERSE: rev_in   = csr_data[0];
            default:     speed_in = speed_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_data.operation)
                  OP_ADD: begin
                     if ((loop_ff && started_ff) || count_ff >= CNT_W'(MAX_POINTS)) begin
                        status_in = ST_REFUSED;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           prev_tmp = '0;
                           pos_in   = mem_wd;
                        end else if (count_ff == CNT_W'(1)) begin
                           next_tmp = prev_tmp + IDX_W'(1);
                        end
                        if (ended_ff && !rev_ff) begin
                           next_tmp = prev_tmp + IDX_W'(1);
                           ended_in = 1'b0;
                        end
                        prev_in = prev_tmp;
                        next_in = next_tmp;
                     end
                  end
                  OP_PLAY: begin
                     if (count_ff == '0) status_in = ST_EMPTY;
                     if (paused_ff) begin
                        paused_in = 1'b0;
                     end else begin
                        ended_in = 1'b0;
                        prev_in  = '0;
                        next_in  = (count_ff >= CNT_W'(2)) ? IDX_W'(1) : '0;
                        if (count_ff != '0) begin
                           snap_addr_in = '0;
                           state_in     = S_SNAP_RD;
                        end
                     end
                  end
                  OP_UPDATE: begin
                     started_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (!(count_ff < CNT_W'(2) || ended_ff || paused_ff)) begin
                        hops_in     = '0;
                        hop_mode_in = 1'b0;
                        state_in    = S_TRAV;
                     end
                  end
                  default: paused_in = 1'b1;
               endcase
            end
         end
         S_TRAV: begin
            mul_a    = {1'b0, speed_ff};
            mul_b    = {1'b0, req_ff.delta_time};
            state_in = S_RD;
         end
         S_RD: begin
            if (!hop_mode_ff) trans_in = prod_ff[63:16];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            if (hop_mode_ff) begin
               pos_in = rd_a_ff;
               d_in[0] = 33'(rd_b_ff.x) - 33'(rd_a_ff.x);
               d_in[1] = 33'(rd_b_ff.y) - 33'(rd_a_ff.y);
               d_in[2] = 33'(rd_b_ff.z) - 33'(rd_a_ff.z);
            end else begin
               d_in[0] = 33'(rd_b_ff.x) - 33'(pos_ff.x);
               d_in[1] = 33'(rd_b_ff.y) - 33'(pos_ff.y);
               d_in[2] = 33'(rd_b_ff.z) - 33'(pos_ff.z);
            end
            cnt_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            case (cnt_ff[1:0])
               2'd0:    mul_a = mag33(d_ff[0]);
               2'd1:    mul_a = mag33(d_ff[1]);
               2'd2:    mul_a = mag33(d_ff[2]);
               default: mul_a = '0;
            endcase
            mul_b  = mul_a;
            acc_in = (cnt_ff == '0) ? '0 : acc_ff + prod_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               rad_in   = {2'b00, acc_ff + prod_ff};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            // one root bit per cycle, restoring
            if (rem_try >= trial) begin
               rem_in  = 36'(rem_try - trial);
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               rem_in  = rem_try[35:0];
               root_in = {root_ff[32:0], 1'b0};
            end
            rad_in = {rad_ff[65:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd33) state_in = S_CHK;
         end
         S_CHK: begin
            if ({14'b0, root_ff} < trans_ff) begin
               if (hops_ff >= HOP_W'(MAX_HOPS)) begin
                  status_in = ST_HOP_CAP;
                  state_in  = S_DONE;
               end else begin
                  hops_in     = hops_ff + HOP_W'(1);
                  trans_in    = trans_ff - {14'b0, root_ff};
                  hop_mode_in = 1'b1;
                  state_in    = S_RD;
                  if (!rev_ff) begin
                     prev_tmp = (prev_p1 >= count_ff) ? '0 : prev_p1[IDX_W-1:0];
                     if (next_p1 >= count_ff) begin
                        if (loop_ff) begin
                           if (link_ff) begin
                              prev_in = prev_tmp;
                              next_in = '0;
                           end else begin
                              prev_in = '0;
                              next_in = IDX_W'(1);
                           end
                        end else begin
                           prev_in      = n_m1;
                           next_in      = n_m1;
                           ended_in     = 1'b1;
                           snap_addr_in = n_m1;
                           state_in     = S_SNAP_RD;
                        end
                     end else begin
                        prev_in = prev_tmp;
                        next_in = next_p1[IDX_W-1:0];
                     end
                  end else begin
                     if (prev_ff == '0) begin
                        if (loop_ff) begin
                           if (link_ff) begin
                              prev_in = n_m1;
                              next_in = '0;
                           end else begin
                              next_in = n_m1;
                              prev_in = n_m2;
                           end
                        end else begin
                           ended_in     = 1'b1;
                           snap_addr_in = '0;
                           state_in     = S_SNAP_RD;
                        end
                     end else if (next_ff == '0) begin
                        next_in = n_m1;
                        prev_in = prev_ff - IDX_W'(1);
                     end else begin
                        prev_in = prev_ff - IDX_W'(1);
                        next_in = next_ff - IDX_W'(1);
                     end
                  end
               end
            end else if (root_ff != '0 && trans_ff != '0) begin
               // travel <= distance here, so it fits the remainder
               divr_in  = {1'b0, trans_ff[33:0]};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_sh >= {1'b0, root_ff}) begin
               divr_in = div_sh - {1'b0, root_ff};
               quo_in  = {quo_ff[29:0], 1'b1};
            end else begin
               divr_in = div_sh;
               quo_in  = {quo_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd30) begin
               cnt_in   = '0;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            case (cnt_ff[1:0])
               2'd0:    mul_a = mag33(d_ff[0]);
               2'd1:    mul_a = mag33(d_ff[1]);
               2'd2:    mul_a = mag33(d_ff[2]);
               default: mul_a = '0;
            endcase
            mul_b = {2'b00, quo_ff};
            // apply the product of the previous axis
            case (cnt_ff[1:0])
               2'd1:    pos_in.x = d_ff[0][32] ? pos_ff.x - off32 : pos_ff.x + off32;
               2'd2:    pos_in.y = d_ff[1][32] ? pos_ff.y - off32 : pos_ff.y + off32;
               2'd3:    pos_in.z = d_ff[2][32] ? pos_ff.z - off32 : pos_ff.z + off32;
               default: pos_in   = pos_ff;
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) state_in = S_DONE;
         end
         S_SNAP_RD: state_in = S_SNAP;
         S_SNAP: begin
            pos_in   = rd_a_ff;
            state_in = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         prev_ff    <= '0;
         next_ff    <= '0;
         pos_ff     <= '0;
         started_ff <= 1'b0;
         ended_ff   <= 1'b0;
         paused_ff  <= 1'b0;
         speed_ff   <= 32'h0001_0000;
         loop_ff    <= 1'b0;
         link_ff    <= 1'b0;
         rev_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         prev_ff    <= prev_in;
         next_ff    <= next_in;
         pos_ff     <= pos_in;
         started_ff <= started_in;
         ended_ff   <= ended_in;
         paused_ff  <= paused_in;
         speed_ff   <= speed_in;
         loop_ff    <= loop_in;
         link_ff    <= link_in;
         rev_ff     <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      req_ff       <= req_in;
      status_ff    <= status_in;
      hop_mode_ff  <= hop_mode_in;
      hops_ff      <= hops_in;
      trans_ff     <= trans_in;
      d_ff         <= d_in;
      prod_ff      <= prod;
      acc_ff       <= acc_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      divr_ff      <= divr_in;
      quo_ff       <= quo_in;
      snap_addr_ff <= snap_addr_in;
   end

   // Writes happen only on an accepted add; reads come in later transactions.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   a_hop_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_HOP_CAP) |-> (hops_ff == HOP_W'(MAX_HOPS)))
      else $error("hop cap flagged without reaching the cap");
`endif

endmodule
